[src/psc_pkg.sv]
// Shared types and constants for the pH sample conditioner.
// Holds the register file layout, the back-end state encoding and the fixed-point constants.
// No dependencies.
package psc_pkg;

    localparam int CFG_DATA_W  = 64;
    localparam int CFG_ADDR_W  = 6;
    localparam int QUEUE_DEPTH = 2;

    localparam int PH_W   = 24;
    localparam int DIFF_W = 33;
    localparam int ACC_W  = 58;
    localparam int SM_W   = 28;
    localparam int PROD_W = 66;

    localparam int RECIP_SHIFT        = 31;
    localparam logic [31:0] RECIP_TEN = 32'd214748365;
    localparam int HALF_TEN           = 5;

    localparam int PH_SEVEN     = 458752;
    localparam int PH_MAX       = 8388607;
    localparam int PH_MIN       = -8388608;
    localparam int JUMP_LIMIT   = 22937;
    localparam int ROUND_HALF12 = 2048;

    localparam logic [1:0] MODE_LINEAR = 2'd1;
    localparam logic [1:0] MODE_DUAL   = 2'd2;

    typedef enum logic [2:0] {
        REG_CONTROL,
        REG_TH_OFFSET,
        REG_TH_SLOPE,
        REG_NEUTRAL,
        REG_LIN_SLOPE,
        REG_ACID_SLOPE,
        REG_BASIC_SLOPE
    } t_reg_idx;

    typedef struct packed {
        logic [5:0]         control;
        logic signed [23:0] th_offset;
        logic signed [23:0] th_slope;
        logic [63:0]        neutral;
        logic [47:0]        lin_slope;
        logic [47:0]        acid_slope;
        logic [47:0]        basic_slope;
    } t_cfg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AVG_MUL,
        ST_AVG_FIN,
        ST_MEDIAN,
        ST_CAL_PREP,
        ST_CAL_HI,
        ST_CAL_LO,
        ST_CAL_FIN,
        ST_SMOOTH,
        ST_SM_MUL,
        ST_SM_FIN,
        ST_EMIT
    } t_back_state;

endpackage

[src/psc_regs.sv]
// Configuration register file with an APB-style access port.
// Depends on psc_pkg for the register layout.
module psc_regs
    import psc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [CFG_ADDR_W-1:0] i_paddr,
    input  logic [CFG_DATA_W-1:0] i_pwdata,
    output logic [CFG_DATA_W-1:0] o_prdata,
    output logic                  o_pready,
    output t_cfg                  o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign reg_idx  = t_reg_idx'(i_paddr[CFG_ADDR_W-1:3]);
    assign wr_en    = i_psel && i_penable && i_pwrite;
    assign o_pready = 1'b1;
    assign o_cfg    = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_CONTROL:     r_cfg.control     <= i_pwdata[5:0];
                REG_TH_OFFSET:   r_cfg.th_offset   <= i_pwdata[23:0];
                REG_TH_SLOPE:    r_cfg.th_slope    <= i_pwdata[23:0];
                REG_NEUTRAL:     r_cfg.neutral     <= i_pwdata;
                REG_LIN_SLOPE:   r_cfg.lin_slope   <= i_pwdata[47:0];
                REG_ACID_SLOPE:  r_cfg.acid_slope  <= i_pwdata[47:0];
                REG_BASIC_SLOPE: r_cfg.basic_slope <= i_pwdata[47:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_CONTROL:     o_prdata = CFG_DATA_W'(r_cfg.control);
            REG_TH_OFFSET:   o_prdata = CFG_DATA_W'(unsigned'(r_cfg.th_offset));
            REG_TH_SLOPE:    o_prdata = CFG_DATA_W'(unsigned'(r_cfg.th_slope));
            REG_NEUTRAL:     o_prdata = r_cfg.neutral;
            REG_LIN_SLOPE:   o_prdata = CFG_DATA_W'(r_cfg.lin_slope);
            REG_ACID_SLOPE:  o_prdata = CFG_DATA_W'(r_cfg.acid_slope);
            REG_BASIC_SLOPE: o_prdata = CFG_DATA_W'(r_cfg.basic_slope);
            default:         o_prdata = '0;
        endcase
    end

endmodule

[src/psc_front.sv]
// Front end: accepts samples, accumulates per-channel block sums and issues jobs.
// Depends on psc_pkg for the configuration struct.
module psc_front
    import psc_pkg::*;
#(
    parameter int SAMPLES_PER_AVERAGE = 10,
    parameter int CHANNEL_COUNT       = 2,
    parameter int SUM_W               = 20
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  logic                i_push,
    input  logic                i_full,
    input  logic                i_channel,
    input  logic signed [15:0]  i_adc_sample,
    output logic                o_job_push,
    output logic [SUM_W+1:0]    o_job
);

    localparam int CNT_W = $clog2(SAMPLES_PER_AVERAGE + 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SAMPLES_PER_AVERAGE - 1);

    logic signed [SUM_W-1:0] r_sum   [CHANNEL_COUNT];
    logic [CNT_W-1:0]        r_count [CHANNEL_COUNT];

    logic                    accept;
    logic                    ch_ok;
    logic                    active;
    logic                    present;
    logic                    block_done;
    logic signed [SUM_W-1:0] sum_next;

    assign accept     = i_push && !i_full;
    assign ch_ok      = (CHANNEL_COUNT > 1) || (i_channel == 1'b0);
    assign present    = i_cfg.control[1];
    assign active     = accept && i_cfg.control[0] && ch_ok;
    assign sum_next   = r_sum[i_channel] + SUM_W'(i_adc_sample);
    assign block_done = r_count[i_channel] == LAST_CNT;

    assign o_job_push = active && (!present || block_done);
    assign o_job      = {i_channel, !present, present ? sum_next : '0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNEL_COUNT; c++) begin
                r_sum[c]   <= '0;
                r_count[c] <= '0;
            end
        end else if (active && present) begin
            if (block_done) begin
                r_sum[i_channel]   <= '0;
                r_count[i_channel] <= '0;
            end else begin
                r_sum[i_channel]   <= sum_next;
                r_count[i_channel] <= r_count[i_channel] + CNT_W'(1);
            end
        end
    end

endmodule

[src/psc_queue.sv]
// Short job queue between the front end and the back end.
// Depends on psc_pkg for the default queue depth.
module psc_queue
    import psc_pkg::*;
#(
    parameter int DATA_W = 22,
    parameter int DEPTH  = QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wptr;
    logic [PTR_W-1:0]  r_rptr;
    logic [CNT_W-1:0]  r_count;

    assign o_full  = r_count == CNT_W'(DEPTH);
    assign o_empty = r_count == '0;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full || i_pop)
        else $error("job pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("job popped from an empty queue");

endmodule

[src/psc_back.sv]
// Back end: block average, median of three, calibration, smoothing and result register.
// Depends on psc_pkg for the state encoding, configuration struct and constants.
module psc_back
    import psc_pkg::*;
#(
    parameter int SAMPLES_PER_AVERAGE = 10,
    parameter int CHANNEL_COUNT       = 2,
    parameter int SUM_W               = 20
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cfg                    i_cfg,
    input  logic                    i_q_empty,
    input  logic [SUM_W+1:0]        i_q_data,
    output logic                    o_q_pop,
    input  logic                    i_pop,
    output logic                    o_empty,
    output logic                    o_out_channel,
    output logic signed [PH_W-1:0]  o_ph_value,
    output logic signed [PH_W-1:0]  o_filtered_voltage
);

    localparam int AVG_W    = SUM_W + 8;
    localparam int MAG_W    = (AVG_W > SM_W) ? AVG_W : SM_W;
    localparam int HALF_AVG = SAMPLES_PER_AVERAGE / 2;
    localparam logic [31:0] RECIP_AVG = 32'(((64'd1 << RECIP_SHIFT)
        + 64'(SAMPLES_PER_AVERAGE) - 64'd1) / 64'(SAMPLES_PER_AVERAGE));

    t_back_state r_state, n_state;

    logic                    r_ch;
    logic                    r_absent;
    logic                    r_neg;
    logic [MAG_W-1:0]        r_mag;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [AVG_W-1:0] r_avg;
    logic signed [AVG_W-1:0] r_filt;
    logic signed [DIFF_W-1:0] r_diff;
    logic signed [23:0]      r_slope;
    logic signed [PH_W-1:0]  r_calc;
    logic signed [PH_W-1:0]  r_ph;

    logic signed [AVG_W-1:0] r_hist  [CHANNEL_COUNT][3];
    logic [1:0]              r_hidx  [CHANNEL_COUNT];
    logic [1:0]              r_fill  [CHANNEL_COUNT];
    logic                    r_first [CHANNEL_COUNT];
    logic signed [PH_W-1:0]  r_cur   [CHANNEL_COUNT];

    logic                    r_out_valid;
    logic                    r_out_ch;
    logic signed [PH_W-1:0]  r_out_ph;
    logic signed [PH_W-1:0]  r_out_filt;

    logic                    out_ld;
    logic                    job_ch;
    logic                    job_absent;
    logic signed [SUM_W-1:0] job_sum;
    logic [SUM_W-1:0]        sum_abs;
    logic [MAG_W-1:0]        avg_mag;
    logic [AVG_W-1:0]        q_avg;
    logic signed [AVG_W-1:0] avg_val;
    logic signed [AVG_W-1:0] h0, h1, h2, lo01, hi01, med;
    logic [1:0]              mode;
    logic signed [DIFF_W-1:0] v7;
    logic signed [DIFF_W-1:0] vx;
    logic signed [DIFF_W-1:0] diff;
    logic signed [23:0]      slope;
    logic signed [32:0]      mul_a, mul_b;
    logic signed [ACC_W-1:0] acc_sum;
    logic signed [ACC_W-1:0] ph_wide;
    logic signed [PH_W-1:0]  ph_sat;
    logic signed [PH_W-1:0]  cur;
    logic signed [PH_W:0]    dph;
    logic [PH_W:0]           dph_abs;
    logic                    jump;
    logic signed [SM_W-1:0]  sm_x;
    logic [SM_W-1:0]         sm_abs;
    logic [MAG_W-1:0]        sm_mag;
    logic [PH_W:0]           q_sm;
    logic signed [PH_W:0]    sm_val;

    assign job_ch     = i_q_data[SUM_W+1];
    assign job_absent = i_q_data[SUM_W];
    assign job_sum    = signed'(i_q_data[SUM_W-1:0]);
    assign sum_abs    = job_sum[SUM_W-1] ? unsigned'(-job_sum) : unsigned'(job_sum);
    assign avg_mag    = MAG_W'({sum_abs, 8'b0}) + MAG_W'(HALF_AVG);

    assign q_avg   = r_prod[RECIP_SHIFT +: AVG_W];
    assign avg_val = r_neg ? -signed'(q_avg) : signed'(q_avg);

    assign h0   = r_hist[r_ch][0];
    assign h1   = r_hist[r_ch][1];
    assign h2   = r_hist[r_ch][2];
    assign lo01 = (h0 < h1) ? h0 : h1;
    assign hi01 = (h0 < h1) ? h1 : h0;
    assign med  = (hi01 < h2) ? hi01 : ((lo01 > h2) ? lo01 : h2);

    assign mode = r_ch ? i_cfg.control[5:4] : i_cfg.control[3:2];
    assign v7   = DIFF_W'(signed'(r_ch ? i_cfg.neutral[63:32] : i_cfg.neutral[31:0]));
    assign vx   = DIFF_W'(r_filt);

    always_comb begin
        unique case (mode)
            MODE_LINEAR: begin
                diff  = vx - v7;
                slope = signed'(r_ch ? i_cfg.lin_slope[47:24] : i_cfg.lin_slope[23:0]);
            end
            MODE_DUAL: begin
                diff = vx - v7;
                if (vx >= v7) begin
                    slope = signed'(r_ch ? i_cfg.acid_slope[47:24]
                                         : i_cfg.acid_slope[23:0]);
                end else begin
                    slope = signed'(r_ch ? i_cfg.basic_slope[47:24]
                                         : i_cfg.basic_slope[23:0]);
                end
            end
            default: begin
                diff  = DIFF_W'(i_cfg.th_offset) - vx;
                slope = i_cfg.th_slope;
            end
        endcase
    end

    always_comb begin
        unique case (r_state)
            ST_AVG_MUL: begin
                mul_a = signed'({1'b0, RECIP_AVG});
                mul_b = signed'(33'(r_mag));
            end
            ST_SM_MUL: begin
                mul_a = signed'({1'b0, RECIP_TEN});
                mul_b = signed'(33'(r_mag));
            end
            ST_CAL_HI: begin
                mul_a = 33'(r_slope);
                mul_b = 33'(signed'(r_diff[DIFF_W-1:16]));
            end
            ST_CAL_LO: begin
                mul_a = 33'(r_slope);
                mul_b = signed'({17'b0, r_diff[15:0]});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign acc_sum = r_acc + ACC_W'(r_prod) + ACC_W'(ROUND_HALF12);
    assign ph_wide = (acc_sum >>> 12) + ACC_W'(PH_SEVEN);
    assign ph_sat  = (ph_wide > ACC_W'(PH_MAX)) ? PH_W'(PH_MAX)
                   : (ph_wide < ACC_W'(PH_MIN)) ? PH_W'(PH_MIN) : PH_W'(ph_wide);

    assign cur     = r_cur[r_ch];
    assign dph     = (PH_W+1)'(r_calc) - (PH_W+1)'(cur);
    assign dph_abs = dph[PH_W] ? unsigned'(-dph) : unsigned'(dph);
    assign jump    = r_first[r_ch] || (dph_abs > (PH_W+1)'(JUMP_LIMIT));
    assign sm_x    = SM_W'(cur) * SM_W'(7) + SM_W'(r_calc) * SM_W'(3);
    assign sm_abs  = sm_x[SM_W-1] ? unsigned'(-sm_x) : unsigned'(sm_x);
    assign sm_mag  = MAG_W'(sm_abs) + MAG_W'(HALF_TEN);
    assign q_sm    = r_prod[RECIP_SHIFT +: PH_W+1];
    assign sm_val  = r_neg ? -signed'(q_sm) : signed'(q_sm);

    always_comb begin
        n_state = r_state;
        o_q_pop = 1'b0;
        out_ld  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_state = job_absent ? ST_EMIT : ST_AVG_MUL;
                end
            end
            ST_AVG_MUL:  n_state = ST_AVG_FIN;
            ST_AVG_FIN:  n_state = ST_MEDIAN;
            ST_MEDIAN:   n_state = ST_CAL_PREP;
            ST_CAL_PREP: n_state = ST_CAL_HI;
            ST_CAL_HI:   n_state = ST_CAL_LO;
            ST_CAL_LO:   n_state = ST_CAL_FIN;
            ST_CAL_FIN:  n_state = ST_SMOOTH;
            ST_SMOOTH:   n_state = jump ? ST_EMIT : ST_SM_MUL;
            ST_SM_MUL:   n_state = ST_SM_FIN;
            ST_SM_FIN:   n_state = ST_EMIT;
            ST_EMIT: begin
                if (!r_out_valid || i_pop) begin
                    out_ld  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        unique case (r_state)
            ST_IDLE: begin
                r_ch     <= job_ch;
                r_absent <= job_absent;
                r_neg    <= job_sum[SUM_W-1];
                r_mag    <= avg_mag;
                r_ph     <= PH_W'(PH_SEVEN);
                r_filt   <= '0;
            end
            ST_AVG_FIN:  r_avg  <= avg_val;
            ST_MEDIAN:   r_filt <= (r_fill[r_ch] == 2'd3) ? med : r_avg;
            ST_CAL_PREP: begin
                r_diff  <= diff;
                r_slope <= slope;
            end
            ST_CAL_LO:   r_acc  <= ACC_W'(r_prod) <<< 16;
            ST_CAL_FIN:  r_calc <= ph_sat;
            ST_SMOOTH: begin
                r_ph  <= r_calc;
                r_neg <= sm_x[SM_W-1];
                r_mag <= sm_mag;
            end
            ST_SM_FIN:   r_ph <= PH_W'(sm_val);
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_AVG_FIN) begin
            r_hist[r_ch][r_hidx[r_ch]] <= avg_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNEL_COUNT; c++) begin
                r_hidx[c]  <= '0;
                r_fill[c]  <= '0;
                r_first[c] <= 1'b1;
                r_cur[c]   <= '0;
            end
        end else begin
            if (r_state == ST_AVG_FIN) begin
                r_hidx[r_ch] <= (r_hidx[r_ch] == 2'd2) ? 2'd0 : r_hidx[r_ch] + 2'd1;
                if (r_fill[r_ch] != 2'd3) begin
                    r_fill[r_ch] <= r_fill[r_ch] + 2'd1;
                end
            end
            if (out_ld) begin
                r_cur[r_ch] <= r_ph;
                if (!r_absent) begin
                    r_first[r_ch] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ld) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ld) begin
            r_out_ch   <= r_ch;
            r_out_ph   <= r_ph;
            r_out_filt <= PH_W'(r_filt);
        end
    end

    assign o_empty            = !r_out_valid;
    assign o_out_channel      = r_out_ch;
    assign o_ph_value         = r_out_ph;
    assign o_filtered_voltage = r_out_filt;

    a_emit_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) && r_out_valid && !i_pop |=> r_state == ST_EMIT)
        else $error("result dropped while output register was occupied");

    a_valid_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_EMIT)
        else $error("output became valid outside the emit step");

endmodule

[src/ph_sample_conditioner.sv]
// Top level of the two-channel pH sample conditioner.
// Depends on psc_pkg, psc_regs, psc_front, psc_queue and psc_back.
//
// Input channel: a sample (channel, adc_sample) is taken when push is high and
// full is low. Samples that finish a block, and every sample while the sensor
// is flagged absent, become jobs in a two-entry queue; other samples are only
// accumulated and give no result.
// Result channel: while empty is low, out_channel, ph_value and
// filtered_voltage show the oldest result; pop takes it.
// The front end takes one sample per cycle while full is low. The back end works
// one job at a time through a sequencer around one shared multiplier, so it takes
// no new job from the queue before the last result is loaded into the result
// register; a job whose output jumps skips the smoothing multiply, and a
// sensor-absent job goes straight to the result register. While the back end is
// busy, the queue absorbs bursts at one sample per cycle until full rises.
// A stalled result receiver holds the back end in its final step; the queue
// then fills and full rises.
// Configuration: APB-style, registers at 8-byte strides, write only while idle.
// Reset (synchronous, active low) clears the configuration, sums, counters,
// history fill and first-reading flags; no clearing pass is needed.
module ph_sample_conditioner
    import psc_pkg::*;
#(
    parameter int SAMPLES_PER_AVERAGE = 10,
    parameter int CHANNEL_COUNT       = 2
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [CFG_ADDR_W-1:0]  paddr,
    input  logic [CFG_DATA_W-1:0]  pwdata,
    output logic [CFG_DATA_W-1:0]  prdata,
    output logic                   pready,
    input  logic                   push,
    output logic                   full,
    input  logic                   i_channel,
    input  logic signed [15:0]     i_adc_sample,
    output logic                   empty,
    input  logic                   pop,
    output logic                   o_out_channel,
    output logic signed [PH_W-1:0] o_ph_value,
    output logic signed [PH_W-1:0] o_filtered_voltage
);

    localparam int SUM_W = 16 + $clog2(SAMPLES_PER_AVERAGE);
    localparam int JOB_W = SUM_W + 2;

    t_cfg             cfg;
    logic             job_push;
    logic [JOB_W-1:0] job_in;
    logic [JOB_W-1:0] job_out;
    logic             q_empty;
    logic             q_pop;

    psc_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_cfg     (cfg)
    );

    psc_front #(
        .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE),
        .CHANNEL_COUNT       (CHANNEL_COUNT),
        .SUM_W               (SUM_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_push       (push),
        .i_full       (full),
        .i_channel    (i_channel),
        .i_adc_sample (i_adc_sample),
        .o_job_push   (job_push),
        .o_job        (job_in)
    );

    psc_queue #(
        .DATA_W (JOB_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_data  (job_out),
        .o_empty (q_empty)
    );

    psc_back #(
        .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE),
        .CHANNEL_COUNT       (CHANNEL_COUNT),
        .SUM_W               (SUM_W)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (cfg),
        .i_q_empty          (q_empty),
        .i_q_data           (job_out),
        .o_q_pop            (q_pop),
        .i_pop              (pop),
        .o_empty            (empty),
        .o_out_channel      (o_out_channel),
        .o_ph_value         (o_ph_value),
        .o_filtered_voltage (o_filtered_voltage)
    );

endmodule
